### rtl/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared constants, setup register layout and types for the prescaled
// timer bank.
// ----------------------------------------------------------------------------
package cpt_pkg;

   localparam int TIMER_COUNT     = 4;
   localparam int SLOTS           = 4;
   localparam int MAX_STEP_CYCLES = 255;

   localparam int COUNT_WIDTH     = 16;
   localparam int WRAP_WIDTH      = 8;
   localparam int ACCUM_WIDTH     = 11;
   localparam int SETUP_WIDTH     = 21;
   localparam int CYCLE_WIDTH     = 8;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int PRESEL_WIDTH    = 2;

   localparam logic [COUNT_WIDTH-1:0] TOP_COUNT = 16'hFFFF;
   localparam logic [WRAP_WIDTH-1:0]  WRAP_MAX  = 8'hFF;

   // setup register layout
   localparam int RELOAD_LSB  = 0;
   localparam int PRESEL_LSB  = 16;
   localparam int CASCADE_BIT = 18;
   localparam int IRQ_EN_BIT  = 19;
   localparam int ENABLE_BIT  = 20;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic start;
      logic run;
   } cell_ctrl_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] count;
      logic [WRAP_WIDTH-1:0]  wraps;
      logic                   irq;
      logic                   pending;
   } cell_status_type;

   function automatic logic [ACCUM_WIDTH-1:0] tick_period(input logic [PRESEL_WIDTH-1:0] sel);
      logic [ACCUM_WIDTH-1:0] per;
      case (sel)
         2'd0:    per = 11'd1;
         2'd1:    per = 11'd64;
         2'd2:    per = 11'd256;
         2'd3:    per = 11'd1024;
         default: per = 11'd1;
      endcase
      return per;
   endfunction

endpackage

### rtl/cpt_cell.sv
// ----------------------------------------------------------------------------
// cpt_cell
// One timer of the bank: setup register, prescale accumulator, counter and
// per-request overflow tally. Overflows go to the next cell through a
// registered carry.
// ----------------------------------------------------------------------------
module cpt_cell
   import cpt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   setup_write,
   input  logic [SETUP_WIDTH-1:0] setup_data,
   input  cell_ctrl_type          ctrl,
   input  logic [CYCLE_WIDTH-1:0] step_cycles,
   input  logic                   prev_carry,
   output logic                   carry_out,
   output cell_status_type        status
);

   logic [SETUP_WIDTH-1:0] setup_ff;
   logic [COUNT_WIDTH-1:0] count_ff,   count_in;
   logic [ACCUM_WIDTH-1:0] accum_ff,   accum_in;
   logic                   running_ff, running_in;
   logic [WRAP_WIDTH-1:0]  wraps_ff,   wraps_in;
   logic                   irq_ff,     irq_in;
   logic                   carry_ff,   carry_in;

   logic [COUNT_WIDTH-1:0] reload;
   logic [ACCUM_WIDTH-1:0] period;
   logic                   enable;
   logic                   cascade;
   logic                   irq_en;
   logic                   pending;
   logic                   own_tick;
   logic                   tick;

   always_comb begin
      reload   = setup_ff[RELOAD_LSB +: COUNT_WIDTH];
      period   = tick_period(setup_ff[PRESEL_LSB +: PRESEL_WIDTH]);
      enable   = setup_ff[ENABLE_BIT];
      cascade  = setup_ff[CASCADE_BIT];
      irq_en   = setup_ff[IRQ_EN_BIT];
      pending  = enable && !cascade && (accum_ff >= period);
      own_tick = ctrl.run && pending;
      // a cascade cell only counts overflows handed over by its neighbor
      tick     = own_tick || (prev_carry && enable && cascade);
   end

   always_comb begin
      count_in   = count_ff;
      accum_in   = accum_ff;
      running_in = running_ff;
      wraps_in   = wraps_ff;
      irq_in     = irq_ff;
      carry_in   = 1'b0;
      if (ctrl.start) begin
         wraps_in = '0;
         irq_in   = 1'b0;
         if (!enable) begin
            running_in = 1'b0;
         end else if (!cascade) begin
            if (!running_ff) begin
               count_in = reload;
            end
            running_in = 1'b1;
            accum_in   = accum_ff + ACCUM_WIDTH'(step_cycles);
         end
      end else begin
         if (own_tick) begin
            accum_in = accum_ff - period;
         end
         if (tick) begin
            if (count_ff == TOP_COUNT) begin
               count_in = reload;
               carry_in = 1'b1;
               irq_in   = irq_ff | irq_en;
               if (wraps_ff != WRAP_MAX) begin
                  wraps_in = wraps_ff + 1'b1;
               end
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ff   <= '0;
         count_ff   <= '0;
         accum_ff   <= '0;
         running_ff <= 1'b0;
         wraps_ff   <= '0;
         irq_ff     <= 1'b0;
         carry_ff   <= 1'b0;
      end else begin
         if (setup_write) begin
            setup_ff <= setup_data;
         end
         count_ff   <= count_in;
         accum_ff   <= accum_in;
         running_ff <= running_in;
         wraps_ff   <= wraps_in;
         irq_ff     <= irq_in;
         carry_ff   <= carry_in;
      end
   end

   assign carry_out      = carry_ff;
   assign status.count   = count_ff;
   assign status.wraps   = wraps_ff;
   assign status.irq     = irq_ff;
   assign status.pending = pending;

endmodule

### rtl/cpt_ctrl.sv
// ----------------------------------------------------------------------------
// cpt_ctrl
// Request sequencer: starts the cells, runs them until no tick is left in
// the chain and hands the snapshot to the response register.
// ----------------------------------------------------------------------------
module cpt_ctrl
   import cpt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  logic          busy,
   output cell_ctrl_type ctrl,
   output logic          load_rsp
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      finish;

   assign finish = (state_ff == ST_RUN) && !busy && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      ctrl.start = 1'b0;
      ctrl.run   = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            ctrl.start = req_valid;
         end
         ST_RUN: begin
            ctrl.run = 1'b1;
            load_rsp = finish;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/cascaded_prescaled_timer_bank_unit.sv
// ----------------------------------------------------------------------------
// cascaded_prescaled_timer_bank_unit
// Four cascadable 16-bit prescaled reload timers built as a chain of cells.
//
// Each request on req_ carries the machine cycles that passed since the last
// one. The block answers every request with one response on rsp_: the four
// counts, the overflows of each timer during the step and the interrupt bits.
// Setup registers are written on csr_ (index 0..3); the user must do so only
// while idle, and the block itself does not enforce it. On the accepting
// edge the step is added to the accumulators; the cells then work off the
// prescaler ticks of the busiest timer (most when its accumulator holds old
// cycles and its period is 1), overflows ripple down the registered cascade
// carries, and the response is registered. One request is worked at a time.
// A new request is taken in the cycle after the previous response is
// registered, even if rsp_ready is still low. If the response register is
// still full when a step ends, the step waits until it drains.
// Reset clears setup registers, counters, accumulators and run marks.
// ----------------------------------------------------------------------------
module cascaded_prescaled_timer_bank_unit
   import cpt_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CYCLE_WIDTH-1:0]     req_elapsed_cycles,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [COUNT_WIDTH-1:0]     rsp_counter_zero,
   output logic [COUNT_WIDTH-1:0]     rsp_counter_one,
   output logic [COUNT_WIDTH-1:0]     rsp_counter_two,
   output logic [COUNT_WIDTH-1:0]     rsp_counter_three,
   output logic [WRAP_WIDTH-1:0]      rsp_wraps_zero,
   output logic [WRAP_WIDTH-1:0]      rsp_wraps_one,
   output logic [WRAP_WIDTH-1:0]      rsp_wraps_two,
   output logic [WRAP_WIDTH-1:0]      rsp_wraps_three,
   output logic [SLOTS-1:0]           rsp_irq_raised,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [SETUP_WIDTH-1:0]     csr_data
);

   cell_ctrl_type          ctrl;
   logic                   busy;
   logic                   load_rsp;
   logic [CYCLE_WIDTH-1:0] step_cycles;

   cell_status_type        status [TIMER_COUNT];
   logic [TIMER_COUNT-1:0] chain;
   logic [TIMER_COUNT-1:0] pending;

   logic [COUNT_WIDTH-1:0] count_slot [SLOTS];
   logic [WRAP_WIDTH-1:0]  wraps_slot [SLOTS];
   logic [SLOTS-1:0]       irq_slot;

   logic [COUNT_WIDTH-1:0] rsp_count_ff [SLOTS];
   logic [WRAP_WIDTH-1:0]  rsp_wraps_ff [SLOTS];
   logic [SLOTS-1:0]       rsp_irq_ff;

   assign step_cycles = (int'(req_elapsed_cycles) > MAX_STEP_CYCLES)
                        ? CYCLE_WIDTH'(MAX_STEP_CYCLES) : req_elapsed_cycles;

   cpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .busy      (busy),
      .ctrl      (ctrl),
      .load_rsp  (load_rsp)
   );

   for (genvar g = 0; g < TIMER_COUNT; g++) begin : g_cell
      logic carry_from_prev;

      if (g == 0) begin : g_head
         assign carry_from_prev = 1'b0;
      end else begin : g_link
         assign carry_from_prev = chain[g-1];
      end

      cpt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .setup_write (csr_write_en && (csr_index == CSR_INDEX_WIDTH'(g))),
         .setup_data  (csr_data),
         .ctrl        (ctrl),
         .step_cycles (step_cycles),
         .prev_carry  (carry_from_prev),
         .carry_out   (chain[g]),
         .status      (status[g])
      );

      assign pending[g] = status[g].pending;
   end

   // step is done once no cell has a tick left and no carry is in flight
   assign busy = (|pending) || (|chain);

   for (genvar s = 0; s < SLOTS; s++) begin : g_slot
      if (s < TIMER_COUNT) begin : g_live
         assign count_slot[s] = status[s].count;
         assign wraps_slot[s] = status[s].wraps;
         assign irq_slot[s]   = status[s].irq;
      end else begin : g_absent
         assign count_slot[s] = '0;
         assign wraps_slot[s] = '0;
         assign irq_slot[s]   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_count_ff <= count_slot;
         rsp_wraps_ff <= wraps_slot;
         rsp_irq_ff   <= irq_slot;
      end
   end

   assign rsp_counter_zero  = rsp_count_ff[0];
   assign rsp_counter_one   = rsp_count_ff[1];
   assign rsp_counter_two   = rsp_count_ff[2];
   assign rsp_counter_three = rsp_count_ff[3];
   assign rsp_wraps_zero    = rsp_wraps_ff[0];
   assign rsp_wraps_one     = rsp_wraps_ff[1];
   assign rsp_wraps_two     = rsp_wraps_ff[2];
   assign rsp_wraps_three   = rsp_wraps_ff[3];
   assign rsp_irq_raised    = rsp_irq_ff;

endmodule

### bench/tb_cascaded_prescaled_timer_bank_unit.sv
// ----------------------------------------------------------------------------
// tb_cascaded_prescaled_timer_bank_unit
// Self-checking bench for the cascadable prescaled timer bank. A driver feeds
// elapsed-cycle requests from a queue, a monitor predicts the four counters,
// overflow counts and interrupt bits of every accepted request and compares
// each response with the oldest prediction. Setup registers are rewritten
// between phases while the bank is idle: a directed part, then random phases.
// ----------------------------------------------------------------------------
module tb_cascaded_prescaled_timer_bank_unit;
   import cpt_pkg::*;

   localparam int CYCLE_LIMIT  = 5_000_000;
   localparam int HOLD_AFTER   = 500;
   localparam int HOLD_CYCLES  = 600;
   localparam int TAIL_CYCLES  = 32;
   localparam int RANDOM_PHASES = 12;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      SETUP_T0,
      SETUP_T1,
      SETUP_T2,
      SETUP_T3
   } setup_index_type;

   typedef enum logic [PRESEL_WIDTH-1:0] {
      DIV_1,
      DIV_64,
      DIV_256,
      DIV_1024
   } prescale_type;

   typedef struct packed {
      logic [SLOTS-1:0][COUNT_WIDTH-1:0] count;
      logic [SLOTS-1:0][WRAP_WIDTH-1:0]  wraps;
      logic [SLOTS-1:0]                  irq;
   } bank_reading_type;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [CYCLE_WIDTH-1:0]     req_elapsed_cycles = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [COUNT_WIDTH-1:0]     rsp_counter_zero;
   logic [COUNT_WIDTH-1:0]     rsp_counter_one;
   logic [COUNT_WIDTH-1:0]     rsp_counter_two;
   logic [COUNT_WIDTH-1:0]     rsp_counter_three;
   logic [WRAP_WIDTH-1:0]      rsp_wraps_zero;
   logic [WRAP_WIDTH-1:0]      rsp_wraps_one;
   logic [WRAP_WIDTH-1:0]      rsp_wraps_two;
   logic [WRAP_WIDTH-1:0]      rsp_wraps_three;
   logic [SLOTS-1:0]           rsp_irq_raised;
   logic                       csr_write_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [SETUP_WIDTH-1:0]     csr_data = '0;

   // shadow of the bank used for prediction
   logic [SETUP_WIDTH-1:0]     setup_q [SLOTS];
   logic [COUNT_WIDTH-1:0]     count_q [SLOTS];
   logic [ACCUM_WIDTH-1:0]     accum_q [SLOTS];
   logic                       running_q [SLOTS];

   logic [CYCLE_WIDTH-1:0]     queued_cycles [$];
   bank_reading_type           expected_readings [$];

   logic req_taken = 1'b0;
   logic steady_flow = 1'b0;
   logic hold_done = 1'b0;
   int   hold_left = 0;
   int   accepted_requests = 0;
   int   error_count = 0;
   int   cycle_count = 0;

   cascaded_prescaled_timer_bank_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_elapsed_cycles (req_elapsed_cycles),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_counter_zero   (rsp_counter_zero),
      .rsp_counter_one    (rsp_counter_one),
      .rsp_counter_two    (rsp_counter_two),
      .rsp_counter_three  (rsp_counter_three),
      .rsp_wraps_zero     (rsp_wraps_zero),
      .rsp_wraps_one      (rsp_wraps_one),
      .rsp_wraps_two      (rsp_wraps_two),
      .rsp_wraps_three    (rsp_wraps_three),
      .rsp_irq_raised     (rsp_irq_raised),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [SETUP_WIDTH-1:0] setup_word(input logic en, input logic irq_en,
                                                        input logic casc,
                                                        input prescale_type sel,
                                                        input logic [COUNT_WIDTH-1:0] reload);
      logic [SETUP_WIDTH-1:0] w;
      w = '0;
      w[ENABLE_BIT]                   = en;
      w[IRQ_EN_BIT]                   = irq_en;
      w[CASCADE_BIT]                  = casc;
      w[PRESEL_LSB +: PRESEL_WIDTH]   = sel;
      w[RELOAD_LSB +: COUNT_WIDTH]    = reload;
      return w;
   endfunction

   // advance the shadow bank by one request and return the expected response
   function automatic bank_reading_type advance_bank(input logic [CYCLE_WIDTH-1:0] cycles);
      bank_reading_type r;
      int unsigned   wrap_n [SLOTS];
      int unsigned   acc;
      int unsigned   per;
      int            k;
      logic          done;
      r = '0;
      for (int i = 0; i < SLOTS; i++) wrap_n[i] = 0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
         if (!setup_q[i][ENABLE_BIT]) begin
            running_q[i] = 1'b0;
            continue;
         end
         if (setup_q[i][CASCADE_BIT]) continue;
         if (!running_q[i]) begin
            count_q[i]   = setup_q[i][RELOAD_LSB +: COUNT_WIDTH];
            running_q[i] = 1'b1;
         end
         case (prescale_type'(setup_q[i][PRESEL_LSB +: PRESEL_WIDTH]))
            DIV_1:    per = 1;
            DIV_64:   per = 64;
            DIV_256:  per = 256;
            default:  per = 1024;
         endcase
         acc = accum_q[i] + cycles;
         while (acc >= per) begin
            acc  = acc - per;
            k    = i;
            done = 1'b0;
            // one tick, carried down the cascade chain on overflow
            while (!done) begin
               if (count_q[k] != TOP_COUNT) begin
                  count_q[k] = count_q[k] + 1'b1;
                  done = 1'b1;
               end else begin
                  count_q[k] = setup_q[k][RELOAD_LSB +: COUNT_WIDTH];
                  if (wrap_n[k] < 255) wrap_n[k]++;
                  if (setup_q[k][IRQ_EN_BIT]) r.irq[k] = 1'b1;
                  if (k >= TIMER_COUNT - 1) begin
                     done = 1'b1;
                  end else begin
                     k++;
                     if (!setup_q[k][ENABLE_BIT] || !setup_q[k][CASCADE_BIT]) done = 1'b1;
                  end
               end
            end
         end
         accum_q[i] = acc[ACCUM_WIDTH-1:0];
      end
      for (int i = 0; i < TIMER_COUNT; i++) begin
         r.count[i] = count_q[i];
         r.wraps[i] = wrap_n[i][WRAP_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic logic take_gap();
      return !steady_flow && ($urandom_range(0, 99) < 33);
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (queued_cycles.size() != 0 && !take_gap()) begin
            req_valid          <= 1'b1;
            req_elapsed_cycles <= queued_cycles.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side, with one long hold-off once enough requests went in
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && accepted_requests >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !take_gap();
      end
   end

   always @(posedge clock) begin : monitor_p
      bank_reading_type got;
      bank_reading_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            expected_readings.push_back(advance_bank(req_elapsed_cycles));
            accepted_requests <= accepted_requests + 1;
         end
         if (rsp_valid && rsp_ready) begin
            got.count = {rsp_counter_three, rsp_counter_two, rsp_counter_one, rsp_counter_zero};
            got.wraps = {rsp_wraps_three, rsp_wraps_two, rsp_wraps_one, rsp_wraps_zero};
            got.irq   = rsp_irq_raised;
            if (expected_readings.size() == 0) begin
               error_count++;
               $display("%0t: response with no request pending, expected none, actual %h",
                        $time, got);
            end else begin
               want = expected_readings.pop_front();
               for (int i = 0; i < SLOTS; i++) begin
                  if (got.count[i] !== want.count[i]) begin
                     error_count++;
                     $display("%0t: timer %0d count mismatch, expected %h, actual %h",
                              $time, i, want.count[i], got.count[i]);
                  end
                  if (got.wraps[i] !== want.wraps[i]) begin
                     error_count++;
                     $display("%0t: timer %0d wraps mismatch, expected %0d, actual %0d",
                              $time, i, want.wraps[i], got.wraps[i]);
                  end
               end
               if (got.irq !== want.irq) begin
                  error_count++;
                  $display("%0t: irq mismatch, expected %b, actual %b",
                           $time, want.irq, got.irq);
               end
            end
         end
      end
   end

   task automatic write_setup(input setup_index_type idx, input logic [SETUP_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      setup_q[idx] = value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // wait for every queued request to be answered
   task automatic settle_bank();
      while (queued_cycles.size() != 0 || req_valid || expected_readings.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [SETUP_WIDTH-1:0] random_setup();
      logic [COUNT_WIDTH-1:0] reload;
      case ($urandom_range(0, 4))
         0:       reload = TOP_COUNT;
         1:       reload = 16'hFF00 + 16'($urandom_range(0, 255));
         2:       reload = 16'hFFF0 + 16'($urandom_range(0, 15));
         3:       reload = '0;
         default: reload = 16'($urandom_range(0, 65535));
      endcase
      return setup_word($urandom_range(0, 99) < 85, 1'($urandom_range(0, 1)),
                        $urandom_range(0, 99) < 30, prescale_type'($urandom_range(0, 3)),
                        reload);
   endfunction

   initial begin : stimulus_p
      int n_items;
      for (int i = 0; i < SLOTS; i++) begin
         setup_q[i]   = '0;
         count_q[i]   = '0;
         accum_q[i]   = '0;
         running_q[i] = 1'b0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all timers disabled after reset, zero and full step
      queued_cycles = '{8'd0, 8'd255};
      settle_bank();

      // free timer zero feeding a cascade chain; timer three cascade but disabled
      write_setup(SETUP_T0, setup_word(1'b1, 1'b1, 1'b0, DIV_1, 16'hFFFE));
      write_setup(SETUP_T1, setup_word(1'b1, 1'b1, 1'b1, DIV_1, 16'hFFFF));
      write_setup(SETUP_T2, setup_word(1'b1, 1'b0, 1'b1, DIV_1, 16'h1234));
      write_setup(SETUP_T3, setup_word(1'b0, 1'b1, 1'b1, DIV_1, 16'hABCD));
      queued_cycles = '{8'd0, 8'd1, 8'd1, 8'd2, 8'd255};
      settle_bank();

      // timer zero in cascade mode never ticks; the others use the slow prescalers
      write_setup(SETUP_T0, setup_word(1'b1, 1'b1, 1'b1, DIV_1, 16'h0000));
      write_setup(SETUP_T1, setup_word(1'b1, 1'b1, 1'b0, DIV_64, 16'hFFF0));
      write_setup(SETUP_T2, setup_word(1'b1, 1'b0, 1'b0, DIV_256, 16'hFFFF));
      write_setup(SETUP_T3, setup_word(1'b1, 1'b1, 1'b0, DIV_1024, 16'hFFFF));
      queued_cycles = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd63, 8'd64};
      settle_bank();

      // prescale change while running drains old cycles, wrap count saturates;
      // disabled timer keeps its count
      write_setup(SETUP_T3, setup_word(1'b1, 1'b1, 1'b0, DIV_1, 16'hFFFF));
      write_setup(SETUP_T2, setup_word(1'b0, 1'b0, 1'b0, DIV_256, 16'hFFFF));
      queued_cycles = '{8'd255, 8'd7};
      settle_bank();

      // restart of timer two, all-ones setup on timer one, all-zero on timer three
      write_setup(SETUP_T0, setup_word(1'b1, 1'b1, 1'b0, DIV_1, 16'hFFFF));
      write_setup(SETUP_T1, {SETUP_WIDTH{1'b1}});
      write_setup(SETUP_T2, setup_word(1'b1, 1'b0, 1'b0, DIV_1, 16'h8000));
      write_setup(SETUP_T3, '0);
      queued_cycles = '{8'd0, 8'd128, 8'd255};
      settle_bank();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         for (int i = 0; i < SLOTS; i++) begin
            // leave some timers running across phases
            if (p == 0 || $urandom_range(0, 99) < 75)
               write_setup(setup_index_type'(i), random_setup());
         end
         steady_flow = (p == 3);
         n_items = $urandom_range(60, 90);
         for (int j = 0; j < n_items; j++) begin
            case ($urandom_range(0, 9))
               0:       queued_cycles.push_back(8'd0);
               1:       queued_cycles.push_back(8'd255);
               default: queued_cycles.push_back(8'($urandom_range(1, 255)));
            endcase
         end
         settle_bank();
      end
      steady_flow = 1'b0;

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_readings.size() != 0) begin
         error_count++;
         $display("%0t: %0d responses never arrived", $time, expected_readings.size());
      end
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
